// ===== hdl/tpba_pkg.sv =====
// Shared types and constants for the two-pool bitmap page allocator.
// No dependencies; every other file of the block uses this package.
package tpba_pkg;

   localparam int PAGE_W         = 52;
   localparam int CNT_W          = 11;
   localparam int STATUS_W       = 3;
   localparam int WORD_BITS      = 32;
   localparam int BIT_W          = 5;
   localparam int WIDX_W         = CNT_W - BIT_W;
   localparam int RUN_W          = CNT_W + 1;
   localparam int POOL_PAGES_DEF = 1024;
   localparam int CSR_IDX_W      = 2;

   localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_RUN   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_USED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_KERN_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERN_TOTAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USER_BASE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_USER_TOTAL = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
      logic [CNT_W-1:0] carry;
   } run_scan_type;

endpackage

// ===== hdl/tpba_bitmap_ram.sv =====
// Used-page bitmap memory: one write port and one registered read port.
// Depends on tpba_pkg for the word width.
module tpba_bitmap_ram #(
   parameter int AW = 7
) (
   input  logic                           clock,
   input  logic                           we,
   input  logic [AW-1:0]                  waddr,
   input  logic [tpba_pkg::WORD_BITS-1:0] wdata,
   input  logic                           re,
   input  logic [AW-1:0]                  raddr,
   output logic [tpba_pkg::WORD_BITS-1:0] rdata
);

   logic [tpba_pkg::WORD_BITS-1:0] mem [2**AW];
   logic [tpba_pkg::WORD_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/tpba_run_scan.sv =====
// Free-run finder over one bitmap word, continuing a run carried in from lower words.
// Depends on tpba_pkg for widths and the result struct.
module tpba_run_scan (
   input  logic [tpba_pkg::WORD_BITS-1:0] avail,
   input  logic [tpba_pkg::CNT_W-1:0]     carry,
   input  logic [tpba_pkg::CNT_W-1:0]     count,
   output tpba_pkg::run_scan_type         result
);

   logic [tpba_pkg::RUN_W-1:0] run [tpba_pkg::WORD_BITS];

   always_comb begin
      for (int j = 0; j < tpba_pkg::WORD_BITS; j++) begin
         logic hit;
         int   lastk;
         hit   = 1'b0;
         lastk = 0;
         for (int k = 0; k < tpba_pkg::WORD_BITS; k++) begin
            if (k <= j && !avail[k]) begin
               hit   = 1'b1;
               lastk = k;
            end
         end
         run[j] = hit ? tpba_pkg::RUN_W'(j - lastk)
                      : tpba_pkg::RUN_W'(carry) + tpba_pkg::RUN_W'(j + 1);
      end
   end

   always_comb begin
      result.found = 1'b0;
      result.pos   = '0;
      result.carry = run[tpba_pkg::WORD_BITS-1][tpba_pkg::CNT_W-1:0];
      for (int j = tpba_pkg::WORD_BITS - 1; j >= 0; j--) begin
         if (run[j] == {1'b0, count}) begin
            result.found = 1'b1;
            result.pos   = tpba_pkg::BIT_W'(j);
         end
      end
   end

endmodule

// ===== hdl/two_pool_bitmap_page_allocator.sv =====
// Two-pool first-fit page allocator: control sequencer, registers and result stage.
// Depends on tpba_pkg, tpba_bitmap_ram and tpba_run_scan.
//
// Usage: a request word on req_* (op 0 allocates page_count pages from the pool that
// from_user picks, op 1 frees the run that starts at page_number) gives exactly one
// response word on rsp_* with the run's first page and a status. Pool bases and sizes
// are to be written through csr_* only while the block is idle; the block itself does
// not enforce it. Both pools live in one bitmap memory of 32-bit words; the logic
// reads, modifies and writes back one word per cycle. An allocation scans words to
// find its run, then marks the words the run spans and loads the response; a free
// first checks its words, then clears them the same way. A request rejected at decode
// goes straight to its response. One item is processed at a time.
// The response sits in an output register; a new request is taken while it waits, and
// a held rsp_stall only delays the next item at its response step.
// After reset the block sweeps the whole bitmap memory (2 * 2**AW words, 64 for
// 1024-page pools) to mark every page used, one word per cycle, with req_stall high.
// Configuration registers reset to zero.
module two_pool_bitmap_page_allocator #(
   parameter int POOL_PAGES = tpba_pkg::POOL_PAGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic                            req_from_user,
   input  logic [tpba_pkg::PAGE_W-1:0]     req_page_number,
   input  logic [tpba_pkg::CNT_W-1:0]      req_page_count,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tpba_pkg::PAGE_W-1:0]     rsp_first_page,
   output logic [tpba_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            csr_write,
   input  logic [tpba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tpba_pkg::PAGE_W-1:0]     csr_wdata
);

   localparam int WORDS = (POOL_PAGES + tpba_pkg::WORD_BITS - 1) / tpba_pkg::WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int MAW   = AW + 1;
   localparam int CAP   = (POOL_PAGES > 2047) ? 2047 : POOL_PAGES;
   localparam logic [tpba_pkg::CNT_W-1:0] CAP_V = tpba_pkg::CNT_W'(CAP);

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_DECODE = 6'b000100,
      S_SCAN   = 6'b001000,
      S_MARK   = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [tpba_pkg::PAGE_W-1:0] kb_ff, ub_ff;
   logic [tpba_pkg::CNT_W-1:0]  kt_ff, ut_ff;

   logic                          op_ff, usr_ff;
   logic [tpba_pkg::PAGE_W-1:0]   page_ff;
   logic [tpba_pkg::CNT_W-1:0]    cnt_ff;

   logic                          pool_ff, pool_in;
   logic [tpba_pkg::CNT_W-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [tpba_pkg::CNT_W-1:0]    total_ff, total_in, first_ff, first_in, run_ff, run_in;
   logic [tpba_pkg::WIDX_W-1:0]   lastw_ff, lastw_in;
   logic [tpba_pkg::PAGE_W-1:0]   base_ff, base_in;
   logic [tpba_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          sel_ff, sel_in;
   logic [tpba_pkg::WIDX_W:0]     rd_w_ff, rd_w_in, ev_w_ff, ev_w_in;
   logic                          ev_valid_ff, ev_valid_in;
   logic [MAW-1:0]                clr_ff;

   logic                          rsp_valid_ff;
   logic [tpba_pkg::PAGE_W-1:0]   rsp_start_ff;
   logic [tpba_pkg::STATUS_W-1:0] rsp_status_ff;

   logic                           mem_we, mem_re;
   logic [MAW-1:0]                 mem_waddr, mem_raddr;
   logic [tpba_pkg::WORD_BITS-1:0] mem_wdata, mem_rdata;

   logic [tpba_pkg::WORD_BITS-1:0] avail, range_mask;
   tpba_pkg::run_scan_type         scan;

   logic                        req_take, rsp_load, rd_en, last_word;
   logic [tpba_pkg::CNT_W-1:0]  kt_eff, ut_eff, sel_total, idx, scan_first, scan_hi;
   logic [tpba_pkg::PAGE_W-1:0] kd, ud;
   logic                        in_k, in_u;

   tpba_bitmap_ram #(.AW(MAW)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   tpba_run_scan u_scan (
      .avail  (avail),
      .carry  (run_ff),
      .count  (cnt_ff),
      .result (scan)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_first_page = rsp_start_ff;
   assign rsp_status     = rsp_status_ff;

   assign rd_en     = (rd_w_ff <= {1'b0, lastw_ff});
   assign last_word = (ev_w_ff == {1'b0, lastw_ff});

   always_comb begin
      for (int j = 0; j < tpba_pkg::WORD_BITS; j++) begin
         logic [tpba_pkg::CNT_W-1:0] p;
         p = {ev_w_ff[tpba_pkg::WIDX_W-1:0], tpba_pkg::BIT_W'(j)};
         avail[j]      = !mem_rdata[j] && (p < total_ff);
         range_mask[j] = (p >= lo_ff) && (p <= hi_ff);
      end
   end

   always_comb begin
      kt_eff = (kt_ff > CAP_V) ? CAP_V : kt_ff;
      ut_eff = (ut_ff > CAP_V) ? CAP_V : ut_ff;
      kd     = page_ff - kb_ff;
      ud     = page_ff - ub_ff;
      in_k   = (page_ff >= kb_ff) && (kd < tpba_pkg::PAGE_W'(kt_eff));
      in_u   = (page_ff >= ub_ff) && (ud < tpba_pkg::PAGE_W'(ut_eff));
      sel_total = in_k ? kt_eff : ut_eff;
      idx       = in_k ? kd[tpba_pkg::CNT_W-1:0] : ud[tpba_pkg::CNT_W-1:0];
      scan_first = ({ev_w_ff[tpba_pkg::WIDX_W-1:0], scan.pos} + tpba_pkg::CNT_W'(1)) - cnt_ff;
      scan_hi    = scan_first + cnt_ff - tpba_pkg::CNT_W'(1);
   end

   always_comb begin
      state_in    = state_ff;
      pool_in     = pool_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      total_in    = total_ff;
      first_in    = first_ff;
      run_in      = run_ff;
      lastw_in    = lastw_ff;
      base_in     = base_ff;
      status_in   = status_ff;
      sel_in      = sel_ff;
      rd_w_in     = rd_w_ff;
      ev_w_in     = ev_w_ff;
      ev_valid_in = 1'b0;
      mem_re      = 1'b0;
      mem_raddr   = {pool_ff, AW'(rd_w_ff[tpba_pkg::WIDX_W-1:0])};
      mem_we      = 1'b0;
      mem_waddr   = {pool_ff, AW'(ev_w_ff[tpba_pkg::WIDX_W-1:0])};
      mem_wdata   = (op_ff == tpba_pkg::OP_ALLOC) ? (mem_rdata | range_mask)
                                                  : (mem_rdata & ~range_mask);
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            sel_in   = 1'b0;
            first_in = '0;
            run_in   = '0;
            ev_w_in  = '0;
            state_in = S_RESP;
            if (op_ff == tpba_pkg::OP_ALLOC) begin
               pool_in  = usr_ff;
               base_in  = usr_ff ? ub_ff : kb_ff;
               total_in = usr_ff ? ut_eff : kt_eff;
               lo_in    = '0;
               hi_in    = total_in - tpba_pkg::CNT_W'(1);
               lastw_in = hi_in[tpba_pkg::CNT_W-1:tpba_pkg::BIT_W];
               rd_w_in  = '0;
               if (cnt_ff == '0) begin
                  status_in = tpba_pkg::ST_DONE;
                  sel_in    = 1'b1;
               end else if (cnt_ff > total_in) begin
                  status_in = tpba_pkg::ST_NO_RUN;
               end else begin
                  state_in = S_SCAN;
               end
            end else if (page_ff == '0 || cnt_ff == '0) begin
               status_in = tpba_pkg::ST_IGNORED;
            end else if (!in_k && !in_u) begin
               status_in = tpba_pkg::ST_OUTSIDE;
            end else if ((tpba_pkg::RUN_W'(idx) + tpba_pkg::RUN_W'(cnt_ff))
                         > tpba_pkg::RUN_W'(sel_total)) begin
               status_in = tpba_pkg::ST_OUTSIDE;
            end else begin
               pool_in  = !in_k;
               total_in = sel_total;
               lo_in    = idx;
               hi_in    = idx + cnt_ff - tpba_pkg::CNT_W'(1);
               lastw_in = hi_in[tpba_pkg::CNT_W-1:tpba_pkg::BIT_W];
               rd_w_in  = {1'b0, idx[tpba_pkg::CNT_W-1:tpba_pkg::BIT_W]};
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            mem_re      = rd_en;
            ev_valid_in = rd_en;
            ev_w_in     = rd_w_ff;
            rd_w_in     = rd_en ? rd_w_ff + 1'b1 : rd_w_ff;
            if (ev_valid_ff) begin
               if (op_ff == tpba_pkg::OP_ALLOC) begin
                  run_in = scan.carry;
                  if (scan.found) begin
                     first_in    = scan_first;
                     lo_in       = scan_first;
                     hi_in       = scan_hi;
                     lastw_in    = scan_hi[tpba_pkg::CNT_W-1:tpba_pkg::BIT_W];
                     rd_w_in     = {1'b0, scan_first[tpba_pkg::CNT_W-1:tpba_pkg::BIT_W]};
                     ev_valid_in = 1'b0;
                     state_in    = S_MARK;
                  end else if (last_word) begin
                     status_in = tpba_pkg::ST_NO_RUN;
                     state_in  = S_RESP;
                  end
               end else if (|(range_mask & ~mem_rdata)) begin
                  status_in = tpba_pkg::ST_NOT_USED;
                  state_in  = S_RESP;
               end else if (last_word) begin
                  rd_w_in     = {1'b0, lo_ff[tpba_pkg::CNT_W-1:tpba_pkg::BIT_W]};
                  ev_valid_in = 1'b0;
                  state_in    = S_MARK;
               end
            end
         end
         S_MARK: begin
            mem_re      = rd_en;
            ev_valid_in = rd_en;
            ev_w_in     = rd_w_ff;
            rd_w_in     = rd_en ? rd_w_ff + 1'b1 : rd_w_ff;
            if (ev_valid_ff) begin
               mem_we = 1'b1;
               if (last_word) begin
                  status_in   = tpba_pkg::ST_DONE;
                  sel_in      = (op_ff == tpba_pkg::OP_ALLOC);
                  ev_valid_in = 1'b0;
                  state_in    = S_RESP;
               end
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kb_ff        <= '0;
         kt_ff        <= '0;
         ub_ff        <= '0;
         ut_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         ev_valid_ff <= ev_valid_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            unique case (csr_index)
               tpba_pkg::CSR_KERN_BASE:  kb_ff <= csr_wdata;
               tpba_pkg::CSR_KERN_TOTAL: kt_ff <= csr_wdata[tpba_pkg::CNT_W-1:0];
               tpba_pkg::CSR_USER_BASE:  ub_ff <= csr_wdata;
               tpba_pkg::CSR_USER_TOTAL: ut_ff <= csr_wdata[tpba_pkg::CNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= req_op;
         usr_ff  <= req_from_user;
         page_ff <= req_page_number;
         cnt_ff  <= req_page_count;
      end
      if (rsp_load) begin
         rsp_start_ff  <= sel_ff ? base_ff + tpba_pkg::PAGE_W'(first_ff) : '0;
         rsp_status_ff <= status_ff;
      end
      pool_ff   <= pool_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      total_ff  <= total_in;
      first_ff  <= first_in;
      run_ff    <= run_in;
      lastw_ff  <= lastw_in;
      base_ff   <= base_in;
      status_ff <= status_in;
      sel_ff    <= sel_in;
      rd_w_ff   <= rd_w_in;
      ev_w_ff   <= ev_w_in;
   end

   a_take_decode: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_DECODE)
      else $error("accepted request did not enter decode");

   a_alloc_in_pool: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK && op_ff == tpba_pkg::OP_ALLOC) |-> hi_ff < total_ff)
      else $error("allocated run extends past pool end");

   a_mark_words: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK && mem_we) |-> ev_w_ff <= {1'b0, lastw_ff})
      else $error("bitmap write outside the run");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != tpba_pkg::ST_DONE) |-> rsp_start_ff == '0)
      else $error("failed word carries a first page");

endmodule

// ===== verif/tb_two_pool_bitmap_page_allocator.sv =====
// Testbench for the two-pool first-fit page allocator: directed and random words
// checked against an in-bench model of both pool bitmaps. Depends on tpba_pkg and
// two_pool_bitmap_page_allocator.
`timescale 1ns / 100ps

module tb_two_pool_bitmap_page_allocator;

   localparam int POOL = tpba_pkg::POOL_PAGES_DEF;
   localparam int LIMIT = 2000000;

   typedef struct packed {
      logic [tpba_pkg::PAGE_W-1:0]   first_page;
      logic [tpba_pkg::STATUS_W-1:0] status;
   } alloc_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_op = 1'b0;
   logic                           req_from_user = 1'b0;
   logic [tpba_pkg::PAGE_W-1:0]    req_page_number = '0;
   logic [tpba_pkg::CNT_W-1:0]     req_page_count = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [tpba_pkg::PAGE_W-1:0]    rsp_first_page;
   logic [tpba_pkg::STATUS_W-1:0]  rsp_status;
   logic                           csr_write = 1'b0;
   logic [tpba_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tpba_pkg::PAGE_W-1:0]    csr_wdata = '0;

   logic [tpba_pkg::PAGE_W-1:0] kern_base, user_base;
   logic [tpba_pkg::CNT_W-1:0]  kern_total, user_total;
   bit                          kern_used [POOL];
   bit                          user_used [POOL];
   alloc_result_type            pending_results [$];
   int                          error_count = 0;
   int                          result_count = 0;
   int                          cycle_count = 0;
   int                          hold_cycles = 0;
   bit                          sink_idle_on = 1'b1;
   bit                          source_idle_on = 1'b1;

   two_pool_bitmap_page_allocator u_top (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Timeout at %0t", $time);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic int pool_size(logic [tpba_pkg::CNT_W-1:0] t);
      return (t > POOL) ? POOL : int'(t);
   endfunction

   function automatic alloc_result_type predict_page_op(logic op, logic from_user,
                                                        logic [tpba_pkg::PAGE_W-1:0] page,
                                                        logic [tpba_pkg::CNT_W-1:0] cnt);
      alloc_result_type r;
      logic [tpba_pkg::PAGE_W-1:0] base;
      int total, run, first, idx;
      bit use_user;
      r.first_page = '0;
      r.status = tpba_pkg::ST_NO_RUN;
      if (op == tpba_pkg::OP_ALLOC) begin
         base = from_user ? user_base : kern_base;
         total = pool_size(from_user ? user_total : kern_total);
         if (cnt == 0) begin
            r.first_page = base;
            r.status = tpba_pkg::ST_DONE;
         end else if (cnt <= total) begin
            run = 0;
            for (int i = 0; i < total; i++) begin
               run = (from_user ? user_used[i] : kern_used[i]) ? 0 : run + 1;
               if (run == cnt) begin
                  first = i + 1 - cnt;
                  for (int k = first; k <= i; k++) begin
                     if (from_user) user_used[k] = 1'b1;
                     else kern_used[k] = 1'b1;
                  end
                  r.first_page = base + tpba_pkg::PAGE_W'(first);
                  r.status = tpba_pkg::ST_DONE;
                  break;
               end
            end
         end
      end else if (page == 0 || cnt == 0) begin
         r.status = tpba_pkg::ST_IGNORED;
      end else begin
         if (page >= kern_base && (page - kern_base) < pool_size(kern_total)) begin
            use_user = 1'b0;
            base = kern_base;
            total = pool_size(kern_total);
         end else if (page >= user_base && (page - user_base) < pool_size(user_total)) begin
            use_user = 1'b1;
            base = user_base;
            total = pool_size(user_total);
         end else begin
            r.status = tpba_pkg::ST_OUTSIDE;
            return r;
         end
         idx = int'(page - base);
         if (idx + cnt > total) begin
            r.status = tpba_pkg::ST_OUTSIDE;
         end else begin
            r.status = tpba_pkg::ST_DONE;
            for (int i = idx; i < idx + cnt; i++) begin
               if (!(use_user ? user_used[i] : kern_used[i])) begin
                  r.status = tpba_pkg::ST_NOT_USED;
                  break;
               end
            end
            if (r.status == tpba_pkg::ST_DONE) begin
               for (int i = idx; i < idx + cnt; i++) begin
                  if (use_user) user_used[i] = 1'b0;
                  else kern_used[i] = 1'b0;
               end
            end
         end
      end
      return r;
   endfunction

   task automatic send_word(logic op, logic from_user, logic [tpba_pkg::PAGE_W-1:0] page,
                            logic [tpba_pkg::CNT_W-1:0] cnt);
      while (source_idle_on && $urandom_range(99) < 30) @(negedge clock);
      req_valid = 1'b1;
      req_op = op;
      req_from_user = from_user;
      req_page_number = page;
      req_page_count = cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(predict_page_op(op, from_user, page, cnt));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain_results();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_csr(logic [tpba_pkg::CSR_IDX_W-1:0] idx,
                            logic [tpba_pkg::PAGE_W-1:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         tpba_pkg::CSR_KERN_BASE:  kern_base = value;
         tpba_pkg::CSR_KERN_TOTAL: kern_total = value[tpba_pkg::CNT_W-1:0];
         tpba_pkg::CSR_USER_BASE:  user_base = value;
         tpba_pkg::CSR_USER_TOTAL: user_total = value[tpba_pkg::CNT_W-1:0];
      endcase
   endtask

   task automatic setup_pools(logic [tpba_pkg::PAGE_W-1:0] kb, logic [tpba_pkg::CNT_W-1:0] kt,
                              logic [tpba_pkg::PAGE_W-1:0] ub, logic [tpba_pkg::CNT_W-1:0] ut);
      drain_results();
      write_csr(tpba_pkg::CSR_KERN_BASE, kb);
      write_csr(tpba_pkg::CSR_KERN_TOTAL, tpba_pkg::PAGE_W'(kt));
      write_csr(tpba_pkg::CSR_USER_BASE, ub);
      write_csr(tpba_pkg::CSR_USER_TOTAL, tpba_pkg::PAGE_W'(ut));
   endtask

   // A random mostly-valid word for the current pools.
   task automatic send_random_word();
      int pick;
      logic [tpba_pkg::PAGE_W-1:0] page;
      logic [tpba_pkg::CNT_W-1:0] cnt;
      logic usr;
      pick = $urandom_range(99);
      usr = 1'($urandom_range(1));
      cnt = ($urandom_range(9) == 0) ? tpba_pkg::CNT_W'($urandom_range(2047)) :
            tpba_pkg::CNT_W'($urandom_range(12));
      if (pick < 50) begin
         send_word(tpba_pkg::OP_ALLOC, usr, tpba_pkg::PAGE_W'({$urandom, $urandom}), cnt);
      end else if (pick < 90) begin
         page = (usr ? user_base : kern_base) +
                tpba_pkg::PAGE_W'($urandom_range(pool_size(usr ? user_total : kern_total)));
         send_word(tpba_pkg::OP_FREE, 1'($urandom_range(1)), page, cnt);
      end else begin
         send_word(tpba_pkg::OP_FREE, usr, tpba_pkg::PAGE_W'({$urandom, $urandom}), cnt);
      end
   endtask

   task automatic test_reset_state();
      setup_pools(52'd0, 11'd64, 52'd100, 11'd64);
      send_word(tpba_pkg::OP_ALLOC, 1'b0, '0, 11'd1);
      send_word(tpba_pkg::OP_ALLOC, 1'b1, '0, 11'd0);
      send_word(tpba_pkg::OP_FREE, 1'b0, '0, 11'd4);
      send_word(tpba_pkg::OP_FREE, 1'b0, 52'd5, 11'd0);
      send_word(tpba_pkg::OP_FREE, 1'b0, 52'd1, 11'd63);
      send_word(tpba_pkg::OP_ALLOC, 1'b0, '0, 11'd1);
      send_word(tpba_pkg::OP_ALLOC, 1'b0, '0, 11'd1);
      send_word(tpba_pkg::OP_FREE, 1'b0, 52'd2, 11'd63);
      send_word(tpba_pkg::OP_FREE, 1'b0, 52'd1, 11'd2);
      send_word(tpba_pkg::OP_FREE, 1'b1, 52'd100, 11'd64);
      send_word(tpba_pkg::OP_FREE, 1'b1, 52'd100, 11'd64);
      send_word(tpba_pkg::OP_ALLOC, 1'b1, '0, 11'd65);
      send_word(tpba_pkg::OP_FREE, 1'b0, 52'd500, 11'd1);
   endtask

   task automatic test_extremes();
      setup_pools({tpba_pkg::PAGE_W{1'b1}} - 52'd9, 11'h7FF, 52'd0, 11'd1024);
      send_word(tpba_pkg::OP_FREE, 1'b0, {tpba_pkg::PAGE_W{1'b1}} - 52'd9, 11'd1024);
      send_word(tpba_pkg::OP_ALLOC, 1'b0, {tpba_pkg::PAGE_W{1'b1}}, 11'd20);
      send_word(tpba_pkg::OP_ALLOC, 1'b0, '0, 11'h7FF);
      send_word(tpba_pkg::OP_FREE, 1'b1, 52'd1, 11'd1023);
      send_word(tpba_pkg::OP_ALLOC, 1'b1, '0, 11'd1);
      send_word(tpba_pkg::OP_ALLOC, 1'b1, '0, 11'd1024);
      send_word(tpba_pkg::OP_FREE, 1'b1, 52'd1, 11'd1023);
      send_word(tpba_pkg::OP_ALLOC, 1'b1, '0, 11'd1023);
      send_word(tpba_pkg::OP_FREE, 1'b0, {tpba_pkg::PAGE_W{1'b1}}, 11'h7FF);
   endtask

   task automatic test_random(int n, logic [tpba_pkg::PAGE_W-1:0] kb,
                              logic [tpba_pkg::CNT_W-1:0] kt,
                              logic [tpba_pkg::PAGE_W-1:0] ub,
                              logic [tpba_pkg::CNT_W-1:0] ut);
      setup_pools(kb, kt, ub, ut);
      send_word(tpba_pkg::OP_FREE, 1'b0, kb == 0 ? 52'd1 : kb, kt);
      send_word(tpba_pkg::OP_FREE, 1'b1, ub == 0 ? 52'd1 : ub, ut);
      repeat (n) send_random_word();
   endtask

   task automatic test_backpressure();
      hold_cycles = 400;
      repeat (20) send_random_word();
      drain_results();
      repeat (20) send_random_word();
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= sink_idle_on && ($urandom_range(99) < 30);
      end
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected word first page %0h status %0d", $time,
                     rsp_first_page, rsp_status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_first_page !== want.first_page || rsp_status !== want.status) begin
               $display("%0t: expected first %0h status %0d, actual first %0h status %0d",
                        $time, want.first_page, want.status, rsp_first_page, rsp_status);
               error_count++;
            end
         end
      end
   end

   initial begin
      kern_base = '0; user_base = '0; kern_total = '0; user_total = '0;
      for (int i = 0; i < POOL; i++) begin
         kern_used[i] = 1'b1;
         user_used[i] = 1'b1;
      end
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_extremes();
      test_random(230, 52'd1, 11'd200, 52'd150, 11'd100);
      sink_idle_on = 1'b0;
      source_idle_on = 1'b0;
      test_random(120, 52'd4096, 11'd96, 52'd0, 11'd2047);
      sink_idle_on = 1'b1;
      source_idle_on = 1'b1;
      test_random(220, {tpba_pkg::PAGE_W{1'b1}} - 52'd40, 11'd64, 52'd7, 11'd48);
      test_backpressure();
      drain_results();
      $display("Covered %0d responses over allocate, free, error and ignore cases,",
               result_count);
      $display("five pool settings including wrap and oversize totals, and a long hold.");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
